/* design/bld_pkg.sv */
// shared types, widths and codes for the bresenham line depth stepper
`default_nettype none

package bld_pkg;

  localparam int COORD_BITS = 13;
  localparam int SPAN_W     = COORD_BITS + 1;
  localparam int DEPTH_W    = 32;
  localparam int ACC_W      = DEPTH_W + 1;
  localparam int COLOUR_W   = 24;
  localparam int DIV_CNT_W  = $clog2(DEPTH_W + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SPAN_W-1:0]     span_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic        [DEPTH_W-1:0]    depth_t;
  typedef logic        [COLOUR_W-1:0]   colour_t;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ORIENT,
    ST_ORDER,
    ST_LAUNCH,
    ST_DIVIDE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic orient;
    logic order;
    logic launch;
    logic finish_zero;
    logic finish_div;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic line_active;
    logic near_reject;
    logic span_zero;
    logic div_done;
  } stat_t;

endpackage

`default_nettype wire

/* design/bld_in_if.sv */
// request channel carrying line start and step requests
`default_nettype none

interface bld_in_if;
  logic                valid;
  logic                ready;
  logic                action;
  bld_pkg::coord_t     start_x;
  bld_pkg::coord_t     start_y;
  bld_pkg::depth_t     start_depth;
  bld_pkg::coord_t     end_x;
  bld_pkg::coord_t     end_y;
  bld_pkg::depth_t     end_depth;
  bld_pkg::colour_t    line_colour;

  modport source (
    output valid, action, start_x, start_y, start_depth,
    output end_x, end_y, end_depth, line_colour,
    input  ready
  );
  modport sink (
    input  valid, action, start_x, start_y, start_depth,
    input  end_x, end_y, end_depth, line_colour,
    output ready
  );
endinterface

`default_nettype wire

/* design/bld_out_if.sv */
// result channel carrying one pixel per step request on an active line
`default_nettype none

interface bld_out_if;
  logic                valid;
  logic                ready;
  bld_pkg::coord_t     pixel_x;
  bld_pkg::coord_t     pixel_y;
  bld_pkg::depth_t     pixel_depth;
  bld_pkg::colour_t    pixel_colour;
  logic                last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_depth, pixel_colour, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_depth, pixel_colour, last_pixel,
    output ready
  );
endinterface

`default_nettype wire

/* design/bld_div.sv */
// restoring divider, one quotient bit per cycle, unsigned magnitudes
`default_nettype none

module bld_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [bld_pkg::DEPTH_W-1:0]   dividend,
  input  wire logic [bld_pkg::SPAN_W-1:0]    divisor,
  output logic                               done,
  output logic [bld_pkg::DEPTH_W-1:0]        quotient
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [bld_pkg::DIV_CNT_W-1:0]   count_r, count_nxt;
  logic [bld_pkg::DEPTH_W-1:0]     quot_r, quot_nxt;
  logic [bld_pkg::SPAN_W-1:0]      rem_r, rem_nxt;
  logic [bld_pkg::SPAN_W-1:0]      divisor_r, divisor_nxt;
  logic [bld_pkg::SPAN_W:0]        trial;
  logic [bld_pkg::SPAN_W:0]        trial_sub;
  logic                            fits;

  always_comb begin
    trial     = {rem_r, quot_r[bld_pkg::DEPTH_W-1]};
    trial_sub = trial - {1'b0, divisor_r};
    fits      = (trial >= {1'b0, divisor_r});

    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    count_nxt   = count_r;
    quot_nxt    = quot_r;
    rem_nxt     = rem_r;
    divisor_nxt = divisor_r;

    if (start) begin
      busy_nxt    = 1'b1;
      count_nxt   = bld_pkg::DIV_CNT_W'(bld_pkg::DEPTH_W);
      quot_nxt    = dividend;
      rem_nxt     = '0;
      divisor_nxt = divisor;
    end else if (busy_r) begin
      quot_nxt  = {quot_r[bld_pkg::DEPTH_W-2:0], fits};
      rem_nxt   = fits ? trial_sub[bld_pkg::SPAN_W-1:0] : trial[bld_pkg::SPAN_W-1:0];
      count_nxt = count_r - bld_pkg::DIV_CNT_W'(1);
      if (count_r == bld_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      count_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r    <= quot_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

`default_nettype wire

/* design/bld_dp.sv */
// datapath: line setup, bresenham stepping, depth accumulation, pixel register
`default_nettype none

module bld_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bld_pkg::cmd_t      cmd,
  output bld_pkg::stat_t          stat,
  input  wire logic               cfg_wr_en,
  input  wire bld_pkg::depth_t    cfg_wr_data,
  input  wire bld_pkg::coord_t    in_start_x,
  input  wire bld_pkg::coord_t    in_start_y,
  input  wire bld_pkg::depth_t    in_start_depth,
  input  wire bld_pkg::coord_t    in_end_x,
  input  wire bld_pkg::coord_t    in_end_y,
  input  wire bld_pkg::depth_t    in_end_depth,
  input  wire bld_pkg::colour_t   in_line_colour,
  output bld_pkg::coord_t         pixel_x,
  output bld_pkg::coord_t         pixel_y,
  output bld_pkg::depth_t         pixel_depth,
  output bld_pkg::colour_t        pixel_colour,
  output logic                    last_pixel
);

  // control state
  logic               near_r, line_active_r, line_active_nxt;
  bld_pkg::depth_t    near_z_r, near_z_nxt;

  // latched endpoints
  bld_pkg::coord_t    x0_r, y0_r, x1_r, y1_r;
  bld_pkg::depth_t    z0_r, z1_r;

  // endpoints in major/minor terms
  bld_pkg::coord_t    mj0_r, mn0_r, mj1_r, mn1_r;

  // line state
  logic               axes_swapped_r, axes_swapped_nxt;
  bld_pkg::coord_t    major_pos_r, major_pos_nxt;
  bld_pkg::coord_t    major_end_r, major_end_nxt;
  bld_pkg::coord_t    minor_pos_r, minor_pos_nxt;
  logic               minor_dir_neg_r, minor_dir_neg_nxt;
  bld_pkg::span_t     step_error_r, step_error_nxt;
  bld_pkg::span_t     major_span_r, major_span_nxt;
  bld_pkg::span_t     minor_span_r, minor_span_nxt;
  bld_pkg::acc_t      depth_acc_r, depth_acc_nxt;
  bld_pkg::acc_t      depth_step_r, depth_step_nxt;
  bld_pkg::acc_t      depth_diff_r, depth_diff_nxt;
  bld_pkg::colour_t   colour_r, colour_nxt;

  // pixel register
  bld_pkg::coord_t    pix_x_r, pix_x_nxt;
  bld_pkg::coord_t    pix_y_r, pix_y_nxt;
  bld_pkg::depth_t    pix_depth_r, pix_depth_nxt;
  bld_pkg::colour_t   pix_colour_r, pix_colour_nxt;
  logic               pix_last_r, pix_last_nxt;

  // setup terms
  bld_pkg::span_t     dx, dy, adx, ady;
  logic               steep;
  logic               reorder;
  bld_pkg::coord_t    mj_first, mj_last, mn_first, mn_last;
  bld_pkg::depth_t    z_first, z_last;
  bld_pkg::span_t     span_new, dmn;
  bld_pkg::acc_t      diff_mag, quot_ext;

  // step terms
  logic               at_last;
  bld_pkg::span_t     err_sub;

  logic               div_done;
  bld_pkg::depth_t    div_quot;

  bld_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.launch),
    .dividend (diff_mag[bld_pkg::DEPTH_W-1:0]),
    .divisor  (major_span_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    // orientation terms
    dx    = bld_pkg::span_t'(x1_r) - bld_pkg::span_t'(x0_r);
    dy    = bld_pkg::span_t'(y1_r) - bld_pkg::span_t'(y0_r);
    adx   = dx[bld_pkg::SPAN_W-1] ? -dx : dx;
    ady   = dy[bld_pkg::SPAN_W-1] ? -dy : dy;
    steep = (ady > adx);

    // ordering terms, equal major coordinates keep order
    reorder  = (mj0_r > mj1_r);
    mj_first = reorder ? mj1_r : mj0_r;
    mj_last  = reorder ? mj0_r : mj1_r;
    mn_first = reorder ? mn1_r : mn0_r;
    mn_last  = reorder ? mn0_r : mn1_r;
    z_first  = reorder ? z1_r : z0_r;
    z_last   = reorder ? z0_r : z1_r;
    span_new = bld_pkg::span_t'(mj_last) - bld_pkg::span_t'(mj_first);
    dmn      = bld_pkg::span_t'(mn_last) - bld_pkg::span_t'(mn_first);

    diff_mag = depth_diff_r[bld_pkg::ACC_W-1] ? -depth_diff_r : depth_diff_r;
    quot_ext = bld_pkg::acc_t'({1'b0, div_quot});

    at_last = (major_pos_r >= major_end_r);
    err_sub = step_error_r - minor_span_r;

    near_z_nxt        = cfg_wr_en ? cfg_wr_data : near_z_r;
    line_active_nxt   = line_active_r;
    axes_swapped_nxt  = axes_swapped_r;
    major_pos_nxt     = major_pos_r;
    major_end_nxt     = major_end_r;
    minor_pos_nxt     = minor_pos_r;
    minor_dir_neg_nxt = minor_dir_neg_r;
    step_error_nxt    = step_error_r;
    major_span_nxt    = major_span_r;
    minor_span_nxt    = minor_span_r;
    depth_acc_nxt     = depth_acc_r;
    depth_step_nxt    = depth_step_r;
    depth_diff_nxt    = depth_diff_r;
    colour_nxt        = colour_r;
    pix_x_nxt         = pix_x_r;
    pix_y_nxt         = pix_y_r;
    pix_depth_nxt     = pix_depth_r;
    pix_colour_nxt    = pix_colour_r;
    pix_last_nxt      = pix_last_r;

    if (cmd.load) begin
      line_active_nxt = 1'b0;
      colour_nxt      = in_line_colour;
    end

    if (cmd.orient) begin
      axes_swapped_nxt = steep;
    end

    if (cmd.order) begin
      major_pos_nxt     = mj_first;
      major_end_nxt     = mj_last;
      minor_pos_nxt     = mn_first;
      major_span_nxt    = span_new;
      minor_span_nxt    = dmn[bld_pkg::SPAN_W-1] ? -dmn : dmn;
      minor_dir_neg_nxt = !(mn_first < mn_last);
      step_error_nxt    = span_new >>> 1;
      depth_acc_nxt     = bld_pkg::acc_t'({1'b0, z_first});
      depth_diff_nxt    = bld_pkg::acc_t'({1'b0, z_last}) - bld_pkg::acc_t'({1'b0, z_first});
    end

    if (cmd.finish_zero) begin
      depth_step_nxt  = '0;
      line_active_nxt = 1'b1;
    end

    if (cmd.finish_div) begin
      depth_step_nxt  = depth_diff_r[bld_pkg::ACC_W-1] ? -quot_ext : quot_ext;
      line_active_nxt = 1'b1;
    end

    if (cmd.step) begin
      pix_x_nxt      = axes_swapped_r ? minor_pos_r : major_pos_r;
      pix_y_nxt      = axes_swapped_r ? major_pos_r : minor_pos_r;
      // accumulator stays between the endpoint depths; clamp below zero anyway
      pix_depth_nxt  = depth_acc_r[bld_pkg::ACC_W-1] ? '0 : depth_acc_r[bld_pkg::DEPTH_W-1:0];
      pix_colour_nxt = colour_r;
      pix_last_nxt   = at_last;
      if (at_last) begin
        line_active_nxt = 1'b0;
      end else begin
        if (err_sub[bld_pkg::SPAN_W-1]) begin
          minor_pos_nxt  = minor_dir_neg_r ? (minor_pos_r - bld_pkg::coord_t'(1))
                                           : (minor_pos_r + bld_pkg::coord_t'(1));
          step_error_nxt = err_sub + major_span_r;
        end else begin
          step_error_nxt = err_sub;
        end
        major_pos_nxt = major_pos_r + bld_pkg::coord_t'(1);
        depth_acc_nxt = depth_acc_r + depth_step_r;
      end
    end
  end

  assign near_r = (z0_r < near_z_r) || (z1_r < near_z_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_z_r      <= '0;
      line_active_r <= 1'b0;
    end else begin
      near_z_r      <= near_z_nxt;
      line_active_r <= line_active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0_r <= in_start_x;
      y0_r <= in_start_y;
      z0_r <= in_start_depth;
      x1_r <= in_end_x;
      y1_r <= in_end_y;
      z1_r <= in_end_depth;
    end
    if (cmd.orient) begin
      mj0_r <= steep ? y0_r : x0_r;
      mn0_r <= steep ? x0_r : y0_r;
      mj1_r <= steep ? y1_r : x1_r;
      mn1_r <= steep ? x1_r : y1_r;
    end
    axes_swapped_r  <= axes_swapped_nxt;
    major_pos_r     <= major_pos_nxt;
    major_end_r     <= major_end_nxt;
    minor_pos_r     <= minor_pos_nxt;
    minor_dir_neg_r <= minor_dir_neg_nxt;
    step_error_r    <= step_error_nxt;
    major_span_r    <= major_span_nxt;
    minor_span_r    <= minor_span_nxt;
    depth_acc_r     <= depth_acc_nxt;
    depth_step_r    <= depth_step_nxt;
    depth_diff_r    <= depth_diff_nxt;
    colour_r        <= colour_nxt;
    pix_x_r         <= pix_x_nxt;
    pix_y_r         <= pix_y_nxt;
    pix_depth_r     <= pix_depth_nxt;
    pix_colour_r    <= pix_colour_nxt;
    pix_last_r      <= pix_last_nxt;
  end

  assign stat.line_active = line_active_r;
  assign stat.near_reject = near_r;
  assign stat.span_zero   = (major_span_r == '0);
  assign stat.div_done    = div_done;

  assign pixel_x      = pix_x_r;
  assign pixel_y      = pix_y_r;
  assign pixel_depth  = pix_depth_r;
  assign pixel_colour = pix_colour_r;
  assign last_pixel   = pix_last_r;

endmodule

`default_nettype wire

/* design/bld_ctrl.sv */
// controller: request handshake, line setup sequence and pixel valid
`default_nettype none

module bld_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_action,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output bld_pkg::cmd_t         cmd,
  input  wire bld_pkg::stat_t   stat
);

  bld_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bld_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      bld_pkg::ST_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        if (in_valid && in_ready) begin
          if (in_action == bld_pkg::ACT_START) begin
            cmd.load  = 1'b1;
            state_nxt = bld_pkg::ST_ORIENT;
          end else if (stat.line_active) begin
            cmd.step      = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      bld_pkg::ST_ORIENT: begin
        cmd.orient = 1'b1;
        state_nxt  = stat.near_reject ? bld_pkg::ST_IDLE : bld_pkg::ST_ORDER;
      end
      bld_pkg::ST_ORDER: begin
        cmd.order = 1'b1;
        state_nxt = bld_pkg::ST_LAUNCH;
      end
      bld_pkg::ST_LAUNCH: begin
        if (stat.span_zero) begin
          cmd.finish_zero = 1'b1;
          state_nxt       = bld_pkg::ST_IDLE;
        end else begin
          cmd.launch = 1'b1;
          state_nxt  = bld_pkg::ST_DIVIDE;
        end
      end
      bld_pkg::ST_DIVIDE: begin
        if (stat.div_done) begin
          cmd.finish_div = 1'b1;
          state_nxt      = bld_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bld_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_step_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> stat.line_active)
    else $error("step issued with no active line");

  a_done_only_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> state_r == bld_pkg::ST_DIVIDE)
    else $error("divider finished outside divide state");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bld_pkg::ST_DIVIDE && stat.div_done) |=> state_r == bld_pkg::ST_IDLE)
    else $error("divide did not return to idle");

  a_line_from_setup: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stat.line_active) |->
      ($past(state_r) == bld_pkg::ST_LAUNCH || $past(state_r) == bld_pkg::ST_DIVIDE))
    else $error("line activated outside setup");

endmodule

`default_nettype wire

/* design/bresenham_line_depth_stepper.sv */
// top level: bresenham line stepper with depth interpolation
//
// in_chan takes requests: action start loads two endpoints with depths and a
// colour, action step asks for the next pixel. out_chan gives one pixel per
// step request while a line is active: x, y, depth, colour and a last flag.
// cfg_wr_en/cfg_wr_data write the near-plane depth; a start whose endpoint
// depth is below it drops the line, and later steps give nothing.
// a step request's pixel is registered and shows on out_chan in the cycle after
// the request is taken; steps stream at one per cycle while out_chan keeps up.
// a start request holds in_chan.ready low for setup: the orientation, ordering
// and launch states, then the depth increment comes from a restoring divider at
// one quotient bit per cycle, captured when it finishes; a zero-length line
// skips the divider and a drop returns to idle after orientation.
// a step with no active line is taken and gives no pixel.
// the pixel sits in an output register; if out_chan stalls, one more step can
// still be taken in the cycle the register drains, otherwise ready stays low.
// reset (rst_n low, synchronous) clears the near plane to zero, ends any line
// and empties the output register.
`default_nettype none

module bresenham_line_depth_stepper (
  input  wire logic             clk,
  input  wire logic             rst_n,
  bld_in_if.sink                in_chan,
  bld_out_if.source             out_chan,
  input  wire logic             cfg_wr_en,
  input  wire bld_pkg::depth_t  cfg_wr_data
);

  bld_pkg::cmd_t  cmd;
  bld_pkg::stat_t stat;

  // sequencing and handshake
  bld_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_action (in_chan.action),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // setup, stepping, divider and pixel register
  bld_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_start_x     (in_chan.start_x),
    .in_start_y     (in_chan.start_y),
    .in_start_depth (in_chan.start_depth),
    .in_end_x       (in_chan.end_x),
    .in_end_y       (in_chan.end_y),
    .in_end_depth   (in_chan.end_depth),
    .in_line_colour (in_chan.line_colour),
    .pixel_x        (out_chan.pixel_x),
    .pixel_y        (out_chan.pixel_y),
    .pixel_depth    (out_chan.pixel_depth),
    .pixel_colour   (out_chan.pixel_colour),
    .last_pixel     (out_chan.last_pixel)
  );

endmodule

`default_nettype wire
